// File: hw/rtl/csb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the stamp blitter.
package csb_pkg;

	// Frame store geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int X_BITS     = $clog2(MAX_WIDTH);
	localparam int Y_BITS     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = X_BITS + Y_BITS;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

	// Stamp geometry
	localparam int STAMP_MAX  = 64;
	localparam int CNT_W      = $clog2(STAMP_MAX);
	localparam int SIZE_W     = 7;

	// Field widths
	localparam int POS_W      = 11;
	localparam int COORD_W    = POS_W + 1;
	localparam int DIM_W      = 9;
	localparam int PIX_W      = 32;
	localparam int PROD_W     = 2 * PIX_W;
	localparam int FRAC_W     = 16;
	localparam int SCL_W      = PROD_W - FRAC_W;
	localparam int SUM_W      = SCL_W + 1;

	// Operation codes
	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_BLANK = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_en;    // write zero at the sweep address, advance sweep
		logic capture;   // accept the beat on the input ports
		logic mem_rd;    // read the frame pixel, form the product
		logic round_en;  // round the product back to Q16.16
		logic commit;    // write back and/or present the read result
	} csb_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;  // sweep is at the last frame address
	} csb_status_t;

endpackage

// File: hw/rtl/csb_ctrl.sv
// Sequencer for the stamp blitter: clearing sweep, then one item at a time.
module csb_ctrl
	import csb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  csb_status_t status,
	output csb_cmd_t    cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				state_d      = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: hw/rtl/csb_datapath.sv
// Datapath: config registers, stamp counters, frame store and scaled add.
module csb_datapath
	import csb_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  csb_cmd_t                    cmd,
	output csb_status_t                 status,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DIM_W-1:0]            cfg_data,
	input  logic [1:0]                  func,
	input  logic [SIZE_W-1:0]           stamp_width,
	input  logic [SIZE_W-1:0]           stamp_height,
	input  logic signed [POS_W-1:0]     pos_x,
	input  logic signed [POS_W-1:0]     pos_y,
	input  logic signed [PIX_W-1:0]     factor,
	input  logic signed [PIX_W-1:0]     element,
	input  logic                        last_element,
	output logic                        done,
	output logic signed [PIX_W-1:0]     read_value
);

	localparam logic [DIM_W-1:0] WIDTH_MAX_C  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX_C = DIM_W'(MAX_HEIGHT);
	localparam logic [SIZE_W-1:0] STAMP_MAX_C = SIZE_W'(STAMP_MAX);
	localparam logic signed [PIX_W-1:0] NO_DATA = {1'b1, {(PIX_W-1){1'b0}}};
	localparam logic signed [PIX_W-1:0] SAT_MAX = {1'b0, {(PIX_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(1) << (FRAC_W - 1);

	logic [DIM_W-1:0]          frame_width_q;
	logic [DIM_W-1:0]          frame_height_q;
	logic [CNT_W-1:0]          col_q;
	logic [CNT_W-1:0]          row_q;
	logic [ADDR_W-1:0]         clr_addr_q;

	logic [1:0]                func_q;
	logic                      hit_q;
	logic [ADDR_W-1:0]         addr_q;
	logic signed [PIX_W-1:0]   factor_q;
	logic signed [PIX_W-1:0]   element_q;
	logic signed [PIX_W-1:0]   rd_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SCL_W-1:0]   scl_q;
	logic                      done_q;
	logic signed [PIX_W-1:0]   value_q;

	logic [PIX_W-1:0]          mem [DEPTH];

	// Config write, with the frame size clamped to the store
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_MAX_C;
			frame_height_q <= HEIGHT_MAX_C;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= clamp_dim(cfg_data, WIDTH_MAX_C);
				REG_FRAME_HEIGHT: frame_height_q <= clamp_dim(cfg_data, HEIGHT_MAX_C);
				default: ;
			endcase
		end
	end

	// Stamp size clamp
	logic [SIZE_W-1:0] w_c, h_c;
	always_comb begin
		w_c = stamp_width;
		if (stamp_width == '0) w_c = SIZE_W'(1);
		else if (stamp_width > STAMP_MAX_C) w_c = STAMP_MAX_C;
		h_c = stamp_height;
		if (stamp_height == '0) h_c = SIZE_W'(1);
		else if (stamp_height > STAMP_MAX_C) h_c = STAMP_MAX_C;
	end

	// Target coordinate: centred in add mode, cornered in blank mode, plain for reads
	logic signed [COORD_W-1:0] off_x, off_y, tx, ty;
	logic [CNT_W-1:0]          cx, cy;
	logic                      in_c;
	always_comb begin
		off_x = '0;
		off_y = '0;
		cx    = col_q;
		cy    = row_q;
		if (func == FUNC_ADD) begin
			off_x = $signed(COORD_W'(w_c >> 1));
			off_y = $signed(COORD_W'(h_c >> 1));
		end
		if (func == FUNC_READ) begin
			cx = '0;
			cy = '0;
		end
		tx = COORD_W'(pos_x) - off_x + $signed(COORD_W'(cx));
		ty = COORD_W'(pos_y) - off_y + $signed(COORD_W'(cy));
		in_c = !tx[COORD_W-1] && !ty[COORD_W-1]
			&& (tx[COORD_W-2:0] < (COORD_W-1)'(frame_width_q))
			&& (ty[COORD_W-2:0] < (COORD_W-1)'(frame_height_q));
	end

	// Stamp counters advance on each add or blank beat
	logic [SIZE_W-1:0] col_nx, row_nx;
	assign col_nx = SIZE_W'(col_q) + SIZE_W'(1);
	assign row_nx = SIZE_W'(row_q) + SIZE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.capture && (func == FUNC_ADD || func == FUNC_BLANK)) begin
			if (last_element) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_nx >= w_c) begin
				col_q <= '0;
				row_q <= (row_nx >= h_c) ? '0 : row_nx[CNT_W-1:0];
			end else begin
				col_q <= col_nx[CNT_W-1:0];
			end
		end
	end

	// Item registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q    <= func;
			hit_q     <= in_c;
			addr_q    <= {ty[Y_BITS-1:0], tx[X_BITS-1:0]};
			factor_q  <= factor;
			element_q <= element;
		end
		if (cmd.mem_rd) prod_q <= factor_q * element_q;
		if (cmd.round_en) scl_q <= SCL_W'((prod_q + ROUND_C) >>> FRAC_W);
	end

	// Saturating add of the rounded product to the frame pixel
	logic signed [SUM_W-1:0] sum_c;
	logic signed [PIX_W-1:0] sat_c;
	always_comb begin
		sum_c = SUM_W'(rd_q) + SUM_W'(scl_q);
		if (sum_c > SUM_W'(SAT_MAX)) sat_c = SAT_MAX;
		else if (sum_c < SUM_W'(NO_DATA)) sat_c = NO_DATA;
		else sat_c = sum_c[PIX_W-1:0];
	end

	// Write port: clearing sweep or commit
	logic              we_c;
	logic [ADDR_W-1:0] wa_c;
	logic [PIX_W-1:0]  wd_c;
	always_comb begin
		we_c = 1'b0;
		wa_c = addr_q;
		wd_c = sat_c;
		if (cmd.clr_en) begin
			we_c = 1'b1;
			wa_c = clr_addr_q;
			wd_c = '0;
		end else if (cmd.commit && hit_q) begin
			case (func_q)
				FUNC_ADD: we_c = 1'b1;
				FUNC_BLANK: begin
					we_c = (element_q != NO_DATA);
					wd_c = factor_q;
				end
				default: we_c = 1'b0;
			endcase
		end
	end

	// Frame store, registered read
	always_ff @(posedge clk) begin
		if (we_c) mem[wa_c] <= wd_c;
		if (cmd.mem_rd) rd_q <= mem[addr_q];
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end
	assign status.clr_last = &clr_addr_q;

	// Read result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit && (func_q == FUNC_READ);
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.commit) value_q <= hit_q ? rd_q : '0;
	end

	assign done       = done_q;
	assign read_value = value_q;

	// Sequencing checks
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.commit))
		else $error("result beat without a commit");
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en |-> !(cmd.capture || cmd.commit || cmd.mem_rd))
		else $error("item activity during clearing sweep");
	a_capture_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.mem_rd ##1 cmd.round_en ##1 cmd.commit)
		else $error("item sequence broken");

endmodule

// File: hw/rtl/clipped_stamp_blitter.sv
// Top level of the clipped stamp blitter: sequencer plus datapath.
//
// channel   signals                                     handshake
// -------   -----------------------------------------   ------------------------
// item in   func stamp_* pos_x pos_y factor element     start && !busy
//           last_element
// result    read_value                                  done, one cycle, no stall
// config    cfg_index cfg_data                          cfg_we, any cycle
//
// After reset the frame store is cleared one pixel a cycle: busy stays high
// until all 65536 pixels (the store depth) are cleared; config writes still land.
// Each item then goes through accept, frame read and multiply, rounding and
// write-back in turn, and the next item is accepted only after write-back.
// A read result appears on done/read_value in the cycle after write-back and
// cannot be held off by the receiver.
module clipped_stamp_blitter
	import csb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               func,
	input  logic [SIZE_W-1:0]        stamp_width,
	input  logic [SIZE_W-1:0]        stamp_height,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [PIX_W-1:0]  factor,
	input  logic signed [PIX_W-1:0]  element,
	input  logic                     last_element,
	output logic                     done,
	output logic signed [PIX_W-1:0]  read_value,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DIM_W-1:0]         cfg_data
);

	csb_cmd_t    cmd;
	csb_status_t status;

	csb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	csb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.stamp_width  (stamp_width),
		.stamp_height (stamp_height),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.factor       (factor),
		.element      (element),
		.last_element (last_element),
		.done         (done),
		.read_value   (read_value)
	);

endmodule
